// ===== rtl/core/sbd_pkg.sv =====
package sbd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int LOG_BITS    = 8;
    localparam int MEM_BITS    = SAMPLE_BITS + 2;
    localparam int ENV_BITS    = 24;
    localparam int ADDR_BITS   = 5;

    localparam logic [31:0] DB_PER_OCT   = 32'd394566;
    localparam logic [31:0] OCT_PER_DB   = 32'd10885;
    localparam logic [15:0] MAX_REDUCE   = 16'd40960;
    localparam logic [31:0] GAIN_UNITY   = 32'h1000_0000;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_HP_ALPHA  = 3'd0;
    localparam logic [2:0] REG_ATTACK    = 3'd1;
    localparam logic [2:0] REG_RELEASE   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_SLOPE     = 3'd4;
    localparam logic [2:0] REG_WIDEBAND  = 3'd5;

    typedef struct packed {
        logic [15:0]        hp_alpha;
        logic [15:0]        rise_coef;
        logic [15:0]        fall_coef;
        logic signed [15:0] threshold_level;
        logic [15:0]        reduction_slope;
        logic               wideband_mode;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HP,
        ST_Y,
        ST_LVL,
        ST_SQ,
        ST_SQEND,
        ST_DB,
        ST_ENV1,
        ST_ENV2,
        ST_ENV3,
        ST_ENV4,
        ST_RED,
        ST_RED2,
        ST_EXP,
        ST_EXP2,
        ST_GAIN,
        ST_GEND,
        ST_OUT1,
        ST_OUT2
    } state_t;

    // integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 2^-(2^-k) in Q.28, from repeated square roots of 0.5
    function automatic logic [31:0] gain_step(input int k);
        logic [63:0] c;
        c = 64'd1 << 27;
        for (int i = 0; i < k; i++) begin
            c = isqrt(c << 28);
        end
        return c[31:0];
    endfunction

    localparam logic [31:0] GAIN_STEP [LOG_BITS] = '{
        gain_step(1), gain_step(2), gain_step(3), gain_step(4),
        gain_step(5), gain_step(6), gain_step(7), gain_step(8)
    };

endpackage

// ===== rtl/core/sbd_mul.sv =====
module sbd_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

endmodule

// ===== rtl/core/sbd_regs.sv =====
module sbd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output sbd_pkg::cfg_t                 cfg
);

    sbd_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign idx = paddr[4:2];
    assign wr  = psel & penable & pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hp_alpha        <= 16'd43018;
            cfg_reg.rise_coef       <= 16'd62862;
            cfg_reg.fall_coef       <= 16'd65468;
            cfg_reg.threshold_level <= -16'sd5120;
            cfg_reg.reduction_slope <= 16'd49152;
            cfg_reg.wideband_mode   <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                sbd_pkg::REG_HP_ALPHA:  cfg_reg.hp_alpha        <= pwdata[15:0];
                sbd_pkg::REG_ATTACK:    cfg_reg.rise_coef       <= pwdata[15:0];
                sbd_pkg::REG_RELEASE:   cfg_reg.fall_coef       <= pwdata[15:0];
                sbd_pkg::REG_THRESHOLD: cfg_reg.threshold_level <= pwdata[15:0];
                sbd_pkg::REG_SLOPE:     cfg_reg.reduction_slope <= pwdata[15:0];
                sbd_pkg::REG_WIDEBAND:  cfg_reg.wideband_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sbd_pkg::REG_HP_ALPHA:  prdata = {16'd0, cfg_reg.hp_alpha};
            sbd_pkg::REG_ATTACK:    prdata = {16'd0, cfg_reg.rise_coef};
            sbd_pkg::REG_RELEASE:   prdata = {16'd0, cfg_reg.fall_coef};
            sbd_pkg::REG_THRESHOLD: prdata = 32'(cfg_reg.threshold_level);
            sbd_pkg::REG_SLOPE:     prdata = {16'd0, cfg_reg.reduction_slope};
            sbd_pkg::REG_WIDEBAND:  prdata = {31'd0, cfg_reg.wideband_mode};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/split_band_deesser_unit.sv =====
// Channel   Dir  Handshake          Word
// input     in   in_valid/in_stall   sample_in (s24 Q1.23)
// output    out  out_valid/out_stall sample_out (s24), reduction_amount (u16 Q8.8 dB)
// config    in   APB psel/penable    6 regs at 4*i, 32-bit data, pready tied high
//
// Every multiply of a word goes through the single registered 32x32 multiplier,
// and the 16 log2 squarings plus the 8 exp2 gain steps make up most of its
// steps. in_stall is high while a word is in flight. The result sits in an
// output register; a new word is taken while it waits, and the sequencer
// holds at its last step while that register is full and out_stall is high.
// rst_n clears the sequencer, filter memory, envelope and registers at once.
module split_band_deesser_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [23:0]            sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [23:0]            sample_out,
    output logic [15:0]                   reduction_amount,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    sbd_pkg::cfg_t   cfg;
    sbd_pkg::state_t state_reg, state_next;

    logic [3:0]         cnt_reg, cnt_next;
    logic signed [23:0] x_reg;
    logic signed [25:0] mem_reg;
    logic signed [25:0] y_reg;
    logic [4:0]         msb_reg;
    logic [30:0]        m_reg;
    logic [15:0]        frac_reg;
    logic signed [17:0] db_reg;
    logic signed [23:0] env_reg;
    logic [16:0]        a_reg;
    logic signed [63:0] acc_reg;
    logic [15:0]        r_reg;
    logic [20:0]        e_reg;
    logic [28:0]        g_reg;

    logic               out_valid_reg;
    logic signed [23:0] sample_out_reg;
    logic [15:0]        red_out_reg;

    logic               mul_en;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;

    logic               out_free;
    logic               finish;

    function automatic logic signed [25:0] sat26(input logic signed [63:0] v);
        if (v > 64'sd33554431)
            return 26'sh1FFFFFF;
        else if (v < -64'sd33554432)
            return 26'sh2000000;
        return v[25:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    sbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sbd_mul u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    assign pready           = 1'b1;
    assign in_stall         = (state_reg != sbd_pkg::ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign sample_out       = sample_out_reg;
    assign reduction_amount = red_out_reg;
    assign out_free         = !out_valid_reg || !out_stall;
    assign finish           = (state_reg == sbd_pkg::ST_OUT2) && out_free;

    // rounded shifts of the product register
    logic signed [63:0] rnd8, rnd16, rnd24, rnd28;
    assign rnd8  = (prod_reg + 64'sd128) >>> 8;
    assign rnd16 = (prod_reg + 64'sd32768) >>> 16;
    assign rnd24 = (prod_reg + 64'sd8388608) >>> 24;
    assign rnd28 = (prod_reg + 64'sd134217728) >>> 28;

    // level detect: |y| floored at 1, leading one, mantissa index
    logic [25:0] lvl;
    logic [4:0]  msb_c;
    logic [25:0] lvl_sh;
    logic [7:0]  idx_c;
    always_comb
    begin
        lvl = y_reg[25] ? 26'(-y_reg) : 26'(y_reg);
        if (lvl == 26'd0)
            lvl = 26'd1;
        msb_c = 5'd0;
        for (int i = 0; i < 26; i++)
        begin
            if (lvl[i])
                msb_c = 5'(i);
        end
        if (msb_c >= 5'd8)
            lvl_sh = lvl >> (msb_c - 5'd8);
        else
            lvl_sh = lvl << (5'd8 - msb_c);
        idx_c = lvl_sh[7:0];
    end

    // squaring step normalize: m*m >> 30, halve when past 2.0
    logic [32:0] sq;
    logic [30:0] m_cur;
    logic        sq_bit;
    assign sq     = prod_reg[62:30];
    assign sq_bit = sq[31];
    always_comb
    begin
        if (cnt_reg == 4'd0)
            m_cur = m_reg;
        else if (sq_bit)
            m_cur = sq[31:1];
        else
            m_cur = sq[30:0];
    end

    logic signed [5:0]  msbm;
    logic signed [21:0] lg;
    assign msbm = $signed(6'(msb_reg)) - 6'sd23;
    assign lg   = $signed({msbm, frac_reg});

    logic [16:0] a_sel;
    assign a_sel = (db_reg > env_reg) ? 17'(cfg.rise_coef) : 17'(cfg.fall_coef);

    logic signed [24:0] over;
    assign over = 25'(env_reg) - 25'(cfg.threshold_level);

    // exp2 steps: one fraction bit of the exponent per step
    logic [7:0]  e_idx;
    logic [2:0]  gstep;
    logic [28:0] g_cur;
    assign e_idx = e_reg[15:8];
    assign gstep = cnt_reg[2:0];
    assign g_cur = (cnt_reg == 4'd0) ? 29'h1000_0000 : rnd28[28:0];

    logic [4:0] whole;
    assign whole = e_reg[20:16];

    logic signed [63:0] res_c;
    assign res_c = cfg.wideband_mode ? rnd28
                                     : 64'(x_reg) - 64'(y_reg) + rnd28;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            sbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = sbd_pkg::ST_HP;
            end
            sbd_pkg::ST_HP:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(cfg.hp_alpha);
                mul_b      = 32'(27'(mem_reg) + 27'(x_reg));
                state_next = sbd_pkg::ST_Y;
            end
            sbd_pkg::ST_Y:    state_next = sbd_pkg::ST_LVL;
            sbd_pkg::ST_LVL:
            begin
                cnt_next   = 4'd0;
                state_next = sbd_pkg::ST_SQ;
            end
            sbd_pkg::ST_SQ:
            begin
                mul_en   = 1'b1;
                mul_a    = 32'(m_cur);
                mul_b    = 32'(m_cur);
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = sbd_pkg::ST_SQEND;
            end
            sbd_pkg::ST_SQEND: state_next = sbd_pkg::ST_DB;
            sbd_pkg::ST_DB:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(lg);
                mul_b      = sbd_pkg::DB_PER_OCT;
                state_next = sbd_pkg::ST_ENV1;
            end
            sbd_pkg::ST_ENV1: state_next = sbd_pkg::ST_ENV2;
            sbd_pkg::ST_ENV2:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(a_sel);
                mul_b      = 32'(env_reg);
                state_next = sbd_pkg::ST_ENV3;
            end
            sbd_pkg::ST_ENV3:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(18'h10000 - 18'(a_reg));
                mul_b      = 32'(db_reg);
                state_next = sbd_pkg::ST_ENV4;
            end
            sbd_pkg::ST_ENV4: state_next = sbd_pkg::ST_RED;
            sbd_pkg::ST_RED:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(over);
                mul_b      = 32'(cfg.reduction_slope);
                state_next = sbd_pkg::ST_RED2;
            end
            sbd_pkg::ST_RED2: state_next = sbd_pkg::ST_EXP;
            sbd_pkg::ST_EXP:
            begin
                mul_en     = 1'b1;
                mul_a      = 32'(r_reg);
                mul_b      = sbd_pkg::OCT_PER_DB;
                state_next = sbd_pkg::ST_EXP2;
            end
            sbd_pkg::ST_EXP2:
            begin
                cnt_next   = 4'd0;
                state_next = sbd_pkg::ST_GAIN;
            end
            sbd_pkg::ST_GAIN:
            begin
                mul_en   = 1'b1;
                mul_a    = 32'(g_cur);
                mul_b    = e_idx[3'd7 - gstep] ? sbd_pkg::GAIN_STEP[gstep]
                                               : sbd_pkg::GAIN_UNITY;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7)
                    state_next = sbd_pkg::ST_GEND;
            end
            sbd_pkg::ST_GEND: state_next = sbd_pkg::ST_OUT1;
            sbd_pkg::ST_OUT1:
            begin
                mul_en     = 1'b1;
                mul_a      = cfg.wideband_mode ? 32'(x_reg) : 32'(y_reg);
                mul_b      = 32'(g_reg);
                state_next = sbd_pkg::ST_OUT2;
            end
            sbd_pkg::ST_OUT2:
            begin
                if (out_free)
                    state_next = sbd_pkg::ST_IDLE;
            end
            default: state_next = sbd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbd_pkg::ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // filter memory and envelope persist across words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_reg <= '0;
            env_reg <= '0;
        end
        else
        begin
            if (state_reg == sbd_pkg::ST_LVL)
                mem_reg <= sat26(64'(27'(y_reg) - 27'(x_reg)));
            if (state_reg == sbd_pkg::ST_ENV4)
                env_reg <= sat24((acc_reg + prod_reg + 64'sd32768) >>> 16);
        end
    end

    // per-word datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    x_reg <= sample_in;
            end
            sbd_pkg::ST_Y:  y_reg <= sat26(rnd16);
            sbd_pkg::ST_LVL:
            begin
                msb_reg  <= msb_c;
                m_reg    <= {1'b1, idx_c, 22'd0};
                frac_reg <= '0;
            end
            sbd_pkg::ST_SQ:
            begin
                if (cnt_reg != 4'd0)
                    frac_reg[4'(5'd16 - 5'(cnt_reg))] <= sq_bit;
            end
            sbd_pkg::ST_SQEND: frac_reg[0] <= sq_bit;
            sbd_pkg::ST_ENV1:  db_reg <= rnd24[17:0];
            sbd_pkg::ST_ENV2:  a_reg  <= a_sel;
            sbd_pkg::ST_ENV3:  acc_reg <= prod_reg;
            sbd_pkg::ST_RED2:
            begin
                if (env_reg <= cfg.threshold_level)
                    r_reg <= '0;
                else if (rnd16 > 64'(sbd_pkg::MAX_REDUCE))
                    r_reg <= sbd_pkg::MAX_REDUCE;
                else if (rnd16 < 64'sd0)
                    r_reg <= '0;
                else
                    r_reg <= rnd16[15:0];
            end
            sbd_pkg::ST_EXP2: e_reg <= rnd8[20:0];
            sbd_pkg::ST_GEND:
            begin
                if (whole >= 5'd31)
                    g_reg <= '0;
                else
                    g_reg <= rnd28[28:0] >> whole;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sample_out_reg <= sat24(res_c);
            red_out_reg    <= r_reg;
        end
    end

endmodule

// ===== dv/tb_split_band_deesser_unit.sv =====
module tb_split_band_deesser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Settle time after the last word, with slack for idle waits.
    localparam int DRAIN_CYCLES = 100;
    // Longest quiet stretch: one word plus a long receiver hold-off.
    localparam int QUIET_LIMIT  = 20000;
    localparam int LONG_HOLD    = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [23:0]            sample_in;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [23:0]            sample_out;
    logic [15:0]                   reduction_amount;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sbd_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    split_band_deesser_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_in        (sample_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_out       (sample_out),
        .reduction_amount (reduction_amount),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Expected output word
    typedef struct {
        logic signed [23:0] smp;
        logic [15:0]        red;
    } deess_word_t;

    // Shadow registers and state of the predictor
    sbd_pkg::cfg_t        shadow_cfg;
    logic signed [25:0]   hp_mem;
    logic signed [23:0]   env_db;
    logic [31:0]          step_tab [sbd_pkg::LOG_BITS];

    deess_word_t          pending_words[$];
    int                   error_count;
    int                   quiet_cycles;
    bit                   sender_idles;
    bit                   receiver_idles;
    bit                   hold_receiver;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor arithmetic
    // ---------------------------------------------------------------
    function automatic longint round_sh(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned sq_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // level in LSBs to dBFS, Q8.8; mantissa truncated to LOG_BITS
    function automatic longint level_db(longint unsigned v);
        int              msb;
        longint unsigned idx;
        longint unsigned m;
        longint          frac;
        longint          lg;
        msb  = 0;
        frac = 0;
        while ((v >> msb) > 1)
            msb++;
        if (msb >= sbd_pkg::LOG_BITS)
            idx = (v >> (msb - sbd_pkg::LOG_BITS)) & ((64'd1 << sbd_pkg::LOG_BITS) - 1);
        else
            idx = (v << (sbd_pkg::LOG_BITS - msb)) & ((64'd1 << sbd_pkg::LOG_BITS) - 1);
        m = ((64'd1 << sbd_pkg::LOG_BITS) + idx) << (30 - sbd_pkg::LOG_BITS);
        for (int k = 1; k <= 16; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m >>= 1;
                frac |= longint'(1) << (16 - k);
            end
        end
        lg = (longint'(msb) - (sbd_pkg::SAMPLE_BITS - 1)) * 65536 + frac;
        return round_sh(lg * 394566, 24);
    endfunction

    // reduction Q8.8 dB to linear gain Q1.28
    function automatic longint reduce_gain(longint r);
        longint          e;
        longint          whole;
        longint unsigned idx;
        longint          g;
        e     = round_sh(r * 10885, 8);
        whole = e >>> 16;
        idx   = (e & 16'hFFFF) >> (16 - sbd_pkg::LOG_BITS);
        g     = longint'(1) << 28;
        for (int k = 1; k <= sbd_pkg::LOG_BITS; k++)
            if ((idx >> (sbd_pkg::LOG_BITS - k)) & 1)
                g = round_sh(g * longint'(step_tab[k - 1]), 28);
        if (whole >= 31)
            return 0;
        return g >>> whole;
    endfunction

    function automatic deess_word_t deess_sample(logic signed [23:0] smp);
        deess_word_t     w;
        longint          x;
        longint          y;
        longint          db;
        longint          a;
        longint          r;
        longint          g;
        longint          res;
        longint unsigned lvl;
        x = smp;
        r = 0;
        y = clip(round_sh(longint'(shadow_cfg.hp_alpha) * (longint'(hp_mem) + x),
                          sbd_pkg::COEF_BITS), sbd_pkg::MEM_BITS);
        hp_mem = 26'(clip(y - x, sbd_pkg::MEM_BITS));
        lvl = (y < 0) ? -y : y;
        if (lvl == 0)
            lvl = 1;
        db = level_db(lvl);
        a = (db > longint'(env_db)) ? shadow_cfg.rise_coef : shadow_cfg.fall_coef;
        env_db = 24'(clip(round_sh(a * longint'(env_db)
                                   + ((longint'(1) << sbd_pkg::COEF_BITS) - a) * db,
                                   sbd_pkg::COEF_BITS), sbd_pkg::ENV_BITS));
        if (longint'(env_db) > longint'(shadow_cfg.threshold_level))
            r = round_sh((longint'(env_db) - longint'(shadow_cfg.threshold_level))
                         * longint'(shadow_cfg.reduction_slope), sbd_pkg::COEF_BITS);
        if (r > 40960)
            r = 40960;
        if (r < 0)
            r = 0;
        g = reduce_gain(r);
        if (shadow_cfg.wideband_mode)
            res = round_sh(x * g, 28);
        else
            res = (x - y) + round_sh(y * g, 28);
        w.smp = 24'(clip(res, sbd_pkg::SAMPLE_BITS));
        w.red = r[15:0];
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Bus and stream drivers
    // ---------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sbd_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sbd_pkg::REG_HP_ALPHA:  shadow_cfg.hp_alpha        = value[15:0];
            sbd_pkg::REG_ATTACK:    shadow_cfg.rise_coef       = value[15:0];
            sbd_pkg::REG_RELEASE:   shadow_cfg.fall_coef       = value[15:0];
            sbd_pkg::REG_THRESHOLD: shadow_cfg.threshold_level = value[15:0];
            sbd_pkg::REG_SLOPE:     shadow_cfg.reduction_slope = value[15:0];
            sbd_pkg::REG_WIDEBAND:  shadow_cfg.wideband_mode   = value[0];
            default: ;
        endcase
    endtask

    // Drives one word and waits for acceptance; prediction is made on accept.
    // valid stays up after the accept; the block is busy for many cycles and
    // the next call either replaces the word or drops valid for a gap.
    task automatic send_word(logic signed [23:0] smp);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(deess_sample(smp));
    endtask

    // Idle until every expected word is out, then let the block settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(logic [15:0] alpha, logic [15:0] att, logic [15:0] rel,
                             logic [15:0] thr, logic [15:0] slope, logic wide);
        drain();
        write_reg(sbd_pkg::REG_HP_ALPHA, {16'h0, alpha});
        write_reg(sbd_pkg::REG_ATTACK, {16'h0, att});
        write_reg(sbd_pkg::REG_RELEASE, {16'h0, rel});
        write_reg(sbd_pkg::REG_THRESHOLD, {{16{thr[15]}}, thr});
        write_reg(sbd_pkg::REG_SLOPE, {16'h0, slope});
        write_reg(sbd_pkg::REG_WIDEBAND, {31'h0, wide});
    endtask

    // Random sample: loud full-range values half of the time, otherwise quiet, mid-level or extreme
    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 24'(signed'($urandom_range(0, 255)) - 128);
            1:       return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            2:       return 24'($urandom_range(0, 65535)) - 24'sd32768;
            default: return 24'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_extremes;
        logic signed [23:0] vals [10];
        vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1,
                 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, 24'sh555555, -24'sh2AAAAB};
        foreach (vals[i])
            send_word(vals[i]);
        // silence after a loud burst: level floored, release path
        repeat (6) send_word(24'sd0);
    endtask

    task automatic test_config_extremes;
        // zero coefficients: filter output zero, envelope follows at once
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        send_word(24'sh7FFFFF);
        send_word(24'sd0);
        send_word(-24'sh800000);
        // maximal coefficients, lowest threshold, large reduction clamp
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0);
        repeat (4) send_word(24'sh7FFFFF);
        send_word(-24'sh800000);
        // positive threshold accepted; zero slope
        write_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b1);
        send_word(24'sh7FFFFF);
        send_word(24'sd1);
    endtask

    task automatic test_random(int n, bit wide);
        write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'(-$urandom_range(0, 24576)), 16'($urandom()), wide);
        repeat (n) send_word(rand_sample());
    endtask

    task automatic test_backpressure;
        sender_idles = 1'b0;
        fork
            begin
                hold_receiver = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_receiver = 1'b0;
            end
            repeat (20) send_word(rand_sample());
        join
        sender_idles = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Receiver stall generation, output checking, watchdog
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        if (hold_receiver)
            out_stall <= 1'b1;
        else if (receiver_idles && $urandom_range(0, 7) == 0)
            out_stall <= 1'b1;
        else if (out_stall && receiver_idles && $urandom_range(0, 2) != 0)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        deess_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("unexpected word", sample_out, 0);
            end
            else
            begin
                w = pending_words.pop_front();
                if (sample_out !== w.smp)
                    report_mismatch("sample_out", sample_out, w.smp);
                if (reduction_amount !== w.red)
                    report_mismatch("reduction_amount", reduction_amount, w.red);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < sbd_pkg::LOG_BITS; k++)
            step_tab[k] = 32'(sq_root(64'd1 << 55));
        // each step is sqrt of the previous, starting from sqrt(0.5)
        begin
            longint unsigned c;
            c = 64'd1 << 27;
            for (int k = 0; k < sbd_pkg::LOG_BITS; k++)
            begin
                c = sq_root(c << 28);
                step_tab[k] = c[31:0];
            end
        end
        shadow_cfg = '{16'd43018, 16'd62862, 16'd65468, -16'sd5120, 16'd49152, 1'b0};
        hp_mem         = '0;
        env_db         = '0;
        error_count    = 0;
        quiet_cycles   = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_receiver  = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_config_extremes();
        test_random(200, 1'b0);
        test_backpressure();
        test_random(200, 1'b1);
        test_random(200, 1'b0);
        // last stretch without idling on either side
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random(300, 1'b1);

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== split_band_deesser_unit.f =====
rtl/core/sbd_pkg.sv
rtl/core/sbd_mul.sv
rtl/core/sbd_regs.sv
rtl/core/split_band_deesser_unit.sv
dv/tb_split_band_deesser_unit.sv
